[rtl/rau_pkg.sv]
// Shared types and constants for the rational arithmetic unit.
// No dependencies.
package rau_pkg;
  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int RES_W = 32;
  localparam int CMP_W = 33;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_t;

  // Datapath micro-operations issued by the controller.
  typedef enum logic [3:0] {
    DC_NOP,
    DC_LOAD,
    DC_CROSS,
    DC_PREP_R,
    DC_PREP_A,
    DC_PREP_B,
    DC_PREP_L,
    DC_GCD_STEP,
    DC_DIV_START,
    DC_DIV_STEP,
    DC_FIN_R,
    DC_FIN_A,
    DC_FIN_B,
    DC_LCM_Q,
    DC_MUL_TERM,
    DC_FIN_CMP
  } dp_cmd_t;

  typedef struct packed {
    dp_cmd_t cmd;
    logic    div_sel;  // 0 divides numerator slot, 1 denominator slot
  } dp_ctrl_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
    logic is_cmp;
    logic lcm_ok;
  } dp_stat_t;
endpackage

[rtl/rau_datapath.sv]
// Datapath of the rational arithmetic unit: cross products, Euclid gcd by
// restoring remainder, restoring divider and compare terms.
// Depends on rau_pkg.
module rau_datapath #(
  parameter int OperandWidth = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rau_pkg::dp_ctrl_t           ctrl,
  output rau_pkg::dp_stat_t           stat,
  input  logic [2:0]                  in_op,
  input  logic signed [OperandWidth-1:0] in_a_num,
  input  logic signed [OperandWidth-1:0] in_a_den,
  input  logic signed [OperandWidth-1:0] in_b_num,
  input  logic signed [OperandWidth-1:0] in_b_den,
  output logic signed [31:0]          res_num,
  output logic signed [31:0]          res_den,
  output logic signed [32:0]          cmp_value,
  output logic                        zero_den_error
);
  import rau_pkg::*;

  localparam int W = OperandWidth;
  localparam int MW = 32;          // magnitude width for gcd and divider
  localparam int CW = $clog2(MW + 1);

  logic [2:0]         op_r;
  logic signed [W-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [31:0] rn_r, rd_r;        // arithmetic result / scratch
  logic signed [W-1:0] ran_r, rad_r, rbn_r, rbd_r; // reduced compare operands
  logic [MW-1:0]      ga_r, gb_r;        // gcd operands
  logic [MW-1:0]      dq_r, drem_r, ddv_r;
  logic [CW-1:0]      dcnt_r;
  logic               dneg_r;
  logic               gmod_r;            // gcd doing a mod via divider
  logic [MW-1:0]      lq_r;              // lcm / den quotient for term
  logic signed [32:0] ta_r, tb_r;
  logic               err_r;
  logic [MW-1:0]      g_r;

  function automatic logic [MW-1:0] mag32(input logic signed [31:0] v);
    return v[31] ? MW'(-v) : MW'(v);
  endfunction

  // restoring divider step
  logic [MW:0] trial;
  assign trial = {drem_r, dq_r[MW-1]} - {1'b0, ddv_r};

  logic signed [31:0] div_src;
  assign div_src = ctrl.div_sel ? rd_r : rn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r <= 1'b0;
      gmod_r <= 1'b0;
    end else begin
      case (ctrl.cmd)
        DC_LOAD: begin
          op_r <= in_op;
          an_r <= in_a_num; ad_r <= in_a_den;
          bn_r <= in_b_num; bd_r <= in_b_den;
          err_r <= (in_a_den == '0) || (in_b_den == '0);
          ta_r <= '0; tb_r <= '0;
        end
        DC_CROSS: begin
          logic signed [31:0] p1, p2, p3, p4, n, d;
          p1 = 32'(an_r * bd_r);
          p2 = 32'(bn_r * ad_r);
          p3 = 32'(an_r * bn_r);
          p4 = 32'(ad_r * bd_r);
          case (op_r)
            OP_ADD: begin n = p1 + p2; d = p4; end
            OP_SUB: begin n = p1 - p2; d = p4; end
            OP_MUL: begin n = p3; d = p4; end
            default: begin n = p1; d = 32'(ad_r * bn_r); end
          endcase
          rn_r <= n;
          rd_r <= (n == 0) ? 32'sd1 : d;
        end
        DC_PREP_R: begin ga_r <= mag32(rn_r); gb_r <= mag32(rd_r); end
        DC_PREP_A: begin
          rn_r <= 32'(an_r); rd_r <= 32'(ad_r);
          ga_r <= mag32(32'(an_r)); gb_r <= mag32(32'(ad_r));
        end
        DC_PREP_B: begin
          rn_r <= 32'(bn_r); rd_r <= 32'(bd_r);
          ga_r <= mag32(32'(bn_r)); gb_r <= mag32(32'(bd_r));
        end
        DC_PREP_L: begin
          ga_r <= mag32(32'(rad_r)); gb_r <= mag32(32'(rbd_r));
        end
        DC_GCD_STEP: begin
          // one Euclid iteration: a mod b by repeated shift-subtract
          if (!gmod_r) begin
            dq_r <= ga_r; drem_r <= '0; ddv_r <= gb_r;
            dcnt_r <= CW'(MW); gmod_r <= 1'b1;
          end else if (dcnt_r != '0) begin
            drem_r <= trial[MW] ? {drem_r[MW-2:0], dq_r[MW-1]} : trial[MW-1:0];
            dq_r <= {dq_r[MW-2:0], ~trial[MW]};
            dcnt_r <= dcnt_r - 1'b1;
          end else begin
            ga_r <= gb_r; gb_r <= drem_r; gmod_r <= 1'b0;
          end
        end
        DC_DIV_START: begin
          g_r <= (ga_r == '0) ? MW'(1) : ga_r;
          dq_r <= mag32(div_src); drem_r <= '0;
          ddv_r <= (ga_r == '0) ? MW'(1) : ga_r;
          dneg_r <= div_src[31];
          dcnt_r <= CW'(MW);
        end
        DC_DIV_STEP: begin
          if (dcnt_r != '0) begin
            drem_r <= trial[MW] ? {drem_r[MW-2:0], dq_r[MW-1]} : trial[MW-1:0];
            dq_r <= {dq_r[MW-2:0], ~trial[MW]};
            dcnt_r <= dcnt_r - 1'b1;
          end else begin
            if (ctrl.div_sel) rd_r <= dneg_r ? -$signed(dq_r) : $signed(dq_r);
            else rn_r <= dneg_r ? -$signed(dq_r) : $signed(dq_r);
            // re-arm for the other slot with the same gcd
            dq_r <= mag32(rd_r); drem_r <= '0; ddv_r <= g_r;
            dneg_r <= rd_r[31]; dcnt_r <= CW'(MW);
          end
        end
        DC_FIN_R: if (rd_r == 0) err_r <= 1'b1;
        DC_FIN_A: begin rad_r <= W'(rd_r); ran_r <= W'(rn_r); end
        DC_FIN_B: begin rbd_r <= W'(rd_r); rbn_r <= W'(rn_r); end
        DC_LCM_Q: begin
          // lcm = (|ad|/g)*|bd|; lcm/ad = sign(ad)*|bd|/g, lcm/bd = sign(bd)*|ad|/g
          // divide |bd| by g first (slot den), then |ad| (slot num)
          rd_r <= 32'(rbd_r); rn_r <= 32'(rad_r);
          g_r <= ga_r;
          dq_r <= mag32(32'(rbd_r)); drem_r <= '0; ddv_r <= ga_r;
          dneg_r <= 1'b0; dcnt_r <= CW'(MW);
        end
        DC_MUL_TERM: begin
          if (dcnt_r != '0) begin
            drem_r <= trial[MW] ? {drem_r[MW-2:0], dq_r[MW-1]} : trial[MW-1:0];
            dq_r <= {dq_r[MW-2:0], ~trial[MW]};
            dcnt_r <= dcnt_r - 1'b1;
          end else if (!ctrl.div_sel) begin
            lq_r <= dq_r;
            dq_r <= mag32(32'(rad_r)); drem_r <= '0; ddv_r <= g_r;
            dcnt_r <= CW'(MW);
          end else begin
            logic signed [65:0] x, y;
            // a term scales by |bd|/g, b term by |ad|/g
            x = $signed({1'b0, lq_r}) * $signed(32'(ran_r));
            y = $signed({1'b0, dq_r}) * $signed(32'(rbn_r));
            ta_r <= rad_r[W-1] ? 33'(-x) : 33'(x);
            tb_r <= rbd_r[W-1] ? 33'(-y) : 33'(y);
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.gcd_done = (gb_r == '0) && !gmod_r;
  assign stat.div_done = (dcnt_r == '0);
  assign stat.is_cmp   = (op_r == OP_CMP);
  assign stat.lcm_ok   = (rad_r != '0) && (rbd_r != '0);

  logic valid_op;
  assign valid_op = (op_r <= OP_CMP);
  assign res_num = (op_r <= OP_DIV) ? rn_r : 32'sd0;
  assign res_den = (op_r <= OP_DIV) ? rd_r : 32'sd1;
  assign cmp_value = (op_r == OP_CMP) ? (tb_r - ta_r) : 33'sd0;
  assign zero_den_error = valid_op ? err_r : 1'b0;
endmodule

[rtl/rau_ctrl.sv]
// Sequencer for the rational arithmetic unit datapath.
// Depends on rau_pkg.
module rau_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_op,
  output logic              out_valid,
  input  logic              out_stall,
  output rau_pkg::dp_ctrl_t ctrl,
  input  rau_pkg::dp_stat_t stat
);
  import rau_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CROSS, S_PREP_R, S_GCD_R, S_DS_R, S_DN_R, S_DD_R, S_FIN_R,
    S_PREP_A, S_GCD_A, S_DS_A, S_DN_A, S_DD_A, S_FIN_A,
    S_PREP_B, S_GCD_B, S_DS_B, S_DN_B, S_DD_B, S_FIN_B,
    S_PREP_L, S_GCD_L, S_LQ, S_TB, S_TA, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r;
    ctrl = '{cmd: DC_NOP, div_sel: 1'b0};
    case (state_r)
      S_IDLE: if (in_valid) begin
        ctrl.cmd = DC_LOAD;
        if (in_op == OP_CMP) state_nxt = S_PREP_A;
        else if (in_op <= OP_DIV) state_nxt = S_CROSS;
        else state_nxt = S_OUT;
      end
      S_CROSS:  begin ctrl.cmd = DC_CROSS; state_nxt = S_PREP_R; end
      S_PREP_R: begin ctrl.cmd = DC_PREP_R; state_nxt = S_GCD_R; end
      S_GCD_R:  begin
        ctrl.cmd = DC_GCD_STEP;
        if (stat.gcd_done) begin ctrl.cmd = DC_NOP; state_nxt = S_DS_R; end
      end
      S_DS_R: begin ctrl.cmd = DC_DIV_START; state_nxt = S_DN_R; end
      S_DN_R: begin
        ctrl.cmd = DC_DIV_STEP;
        if (stat.div_done) state_nxt = S_DD_R;
      end
      S_DD_R: begin
        ctrl.cmd = DC_DIV_STEP; ctrl.div_sel = 1'b1;
        if (stat.div_done) state_nxt = S_FIN_R;
      end
      S_FIN_R: begin ctrl.cmd = DC_FIN_R; state_nxt = S_OUT; end
      S_PREP_A: begin ctrl.cmd = DC_PREP_A; state_nxt = S_GCD_A; end
      S_GCD_A: begin
        ctrl.cmd = DC_GCD_STEP;
        if (stat.gcd_done) begin ctrl.cmd = DC_NOP; state_nxt = S_DS_A; end
      end
      S_DS_A: begin ctrl.cmd = DC_DIV_START; state_nxt = S_DN_A; end
      S_DN_A: begin ctrl.cmd = DC_DIV_STEP; if (stat.div_done) state_nxt = S_DD_A; end
      S_DD_A: begin
        ctrl.cmd = DC_DIV_STEP; ctrl.div_sel = 1'b1;
        if (stat.div_done) state_nxt = S_FIN_A;
      end
      S_FIN_A: begin ctrl.cmd = DC_FIN_A; state_nxt = S_PREP_B; end
      S_PREP_B: begin ctrl.cmd = DC_PREP_B; state_nxt = S_GCD_B; end
      S_GCD_B: begin
        ctrl.cmd = DC_GCD_STEP;
        if (stat.gcd_done) begin ctrl.cmd = DC_NOP; state_nxt = S_DS_B; end
      end
      S_DS_B: begin ctrl.cmd = DC_DIV_START; state_nxt = S_DN_B; end
      S_DN_B: begin ctrl.cmd = DC_DIV_STEP; if (stat.div_done) state_nxt = S_DD_B; end
      S_DD_B: begin
        ctrl.cmd = DC_DIV_STEP; ctrl.div_sel = 1'b1;
        if (stat.div_done) state_nxt = S_FIN_B;
      end
      S_FIN_B: begin ctrl.cmd = DC_FIN_B; state_nxt = S_PREP_L; end
      S_PREP_L: begin
        // a zero denominator leaves both terms at zero
        if (stat.lcm_ok) begin ctrl.cmd = DC_PREP_L; state_nxt = S_GCD_L; end
        else state_nxt = S_OUT;
      end
      S_GCD_L: begin
        ctrl.cmd = DC_GCD_STEP;
        if (stat.gcd_done) begin ctrl.cmd = DC_NOP; state_nxt = S_LQ; end
      end
      S_LQ: begin ctrl.cmd = DC_LCM_Q; state_nxt = S_TB; end
      S_TB: begin ctrl.cmd = DC_MUL_TERM; if (stat.div_done) state_nxt = S_TA; end
      S_TA: begin
        ctrl.cmd = DC_MUL_TERM;
        if (stat.div_done) begin ctrl.div_sel = 1'b1; state_nxt = S_OUT; end
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        if (out_valid_r && !out_stall) begin
          out_valid_nxt = 1'b0; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
endmodule

[rtl/rational_arithmetic_unit.sv]
// Rational arithmetic unit: add, subtract, multiply, divide and compare
// of two signed fractions with gcd reduction.
// Usage:
//   Input channel in_valid/in_stall carries op and the two fractions;
//   an item is taken when in_valid is high and in_stall low.
//   Result channel out_valid/out_stall carries res_num, res_den,
//   cmp_value and zero_den_error, held while out_stall is high.
//   One item is worked at a time; in_stall is high from acceptance
//   until its result is taken.
//   Arithmetic ops run one gcd, k Euclid iterations of the shared
//   32-step shift-subtract remainder unit; compare runs that unit for
//   three gcds and six quotients. Unused op codes go straight from idle
//   to the result state.
//   Rate is set by the one serial divider that serves gcd and quotients.
//   Synchronous active-low reset returns the sequencer to idle and drops
//   out_valid. A stalled result stays on the ports unchanged.
//   Dependencies: rau_pkg, rau_ctrl, rau_datapath.
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_op,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_den,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_res_num,
  output logic signed [31:0]            out_res_den,
  output logic signed [32:0]            out_cmp_value,
  output logic                          out_zero_den_error
);
  import rau_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  rau_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_op,
    .out_valid, .out_stall, .ctrl, .stat
  );

  rau_datapath #(.OperandWidth(OPERAND_WIDTH)) u_dp (
    .clk, .rst_n, .ctrl, .stat, .in_op,
    .in_a_num, .in_a_den, .in_b_num, .in_b_den,
    .res_num(out_res_num), .res_den(out_res_den),
    .cmp_value(out_cmp_value), .zero_den_error(out_zero_den_error)
  );
endmodule

[tb/tb_rational_arithmetic_unit.sv]
// Self-checking testbench for rational_arithmetic_unit: directed table, then random items.
// Uses rau_pkg for op codes; predicts untyped results in its own fraction arithmetic, typed rows carry theirs.
`timescale 1ns / 100ps
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  localparam int W = 16;
  localparam int RANDOM_ITEMS = 1000;
  localparam int QUIET_ITEMS = 150;
  localparam int HOLD_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 20_000_000;
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  typedef struct packed {
    logic signed [31:0] num;
    logic signed [31:0] den;
    logic signed [32:0] cmp;
    logic               err;
  } frac_result_t;

  typedef struct packed {
    logic [2:0]          op;
    logic signed [W-1:0] a_num;
    logic signed [W-1:0] a_den;
    logic signed [W-1:0] b_num;
    logic signed [W-1:0] b_den;
    logic                typed;
    frac_result_t        res;
  } stim_row_t;

  localparam int N_DIRECTED = 20;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{OP_ADD, 16'sd0, 16'sd1, 16'sd0, 16'sd1, 1'b1, '{32'sd0, 32'sd1, 33'sd0, 1'b0}},
    '{OP_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd1, 1'b1, '{32'sd1, 32'sd0, 33'sd0, 1'b1}},
    '{OP_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd3, 1'b0, '0},
    '{OP_MUL, 16'sd32767, 16'sd1, 16'sd32767, 16'sd1, 1'b1,
      '{32'sd1073676289, 32'sd1, 33'sd0, 1'b0}},
    '{OP_MUL, -16'sd32767, 16'sd1, 16'sd32767, 16'sd1, 1'b1,
      '{-32'sd1073676289, 32'sd1, 33'sd0, 1'b0}},
    '{OP_DIV, 16'sd1, 16'sd1, 16'sd0, 16'sd1, 1'b1, '{32'sd1, 32'sd0, 33'sd0, 1'b1}},
    '{OP_DIV, 16'sd0, 16'sd1, 16'sd0, 16'sd1, 1'b1, '{32'sd0, 32'sd1, 33'sd0, 1'b0}},
    '{OP_DIV, 16'sd3, 16'sd4, -16'sd5, 16'sd6, 1'b0, '0},
    '{OP_CMP, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 1'b1, '{32'sd0, 32'sd1, 33'sd0, 1'b1}},
    '{OP_CMP, 16'sd1, 16'sd2, 16'sd1, 16'sd3, 1'b0, '0},
    '{OP_CMP, -16'sd32767, 16'sd32767, 16'sd32767, -16'sd1, 1'b0, '0},
    '{OP_ADD, 16'sd32767, -16'sd32767, -16'sd32767, 16'sd32767, 1'b0, '0},
    '{OP_SUB, -16'sd32767, -16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0},
    '{OP_ADD, 16'sd2, 16'sd4, 16'sd2, 16'sd4, 1'b0, '0},
    '{OP_MUL, 16'sd0, 16'sd5, 16'sd7, 16'sd0, 1'b0, '0},
    '{OP_CMP, 16'sd6, -16'sd4, -16'sd9, 16'sd6, 1'b0, '0},
    '{OP_RSVD5, 16'sd5, 16'sd0, 16'sd3, 16'sd0, 1'b1, '{32'sd0, 32'sd1, 33'sd0, 1'b0}},
    '{OP_RSVD6, -16'sd1, 16'sd2, 16'sd3, 16'sd4, 1'b1, '{32'sd0, 32'sd1, 33'sd0, 1'b0}},
    '{OP_RSVD7, 16'sd32767, 16'sd32767, -16'sd32767, -16'sd32767, 1'b1,
      '{32'sd0, 32'sd1, 33'sd0, 1'b0}},
    '{OP_DIV, 16'sd32767, 16'sd32767, -16'sd32767, 16'sd1, 1'b0, '0}
  };

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [2:0]          in_op;
  logic signed [W-1:0] in_a_num, in_a_den, in_b_num, in_b_den;
  logic                out_valid;
  logic                out_stall;
  logic signed [31:0]  out_res_num, out_res_den;
  logic signed [32:0]  out_cmp_value;
  logic                out_zero_den_error;

  frac_result_t pending_results[$];
  int           fail_count;
  longint       cycle_count;
  bit           quiet;
  bit           hold_request;

  rational_arithmetic_unit #(.OPERAND_WIDTH(W)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_a_num(in_a_num), .in_a_den(in_a_den), .in_b_num(in_b_num), .in_b_den(in_b_den),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_res_num(out_res_num), .out_res_den(out_res_den),
    .out_cmp_value(out_cmp_value), .out_zero_den_error(out_zero_den_error)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint gcd_mag(longint x, longint y);
    longint t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Divide both parts by their positive gcd; 0/0 stays as it is.
  function automatic void reduce_frac(inout longint n, inout longint d);
    longint g;
    g = gcd_mag(mag(n), mag(d));
    if (g == 0) g = 1;
    n = n / g;
    d = d / g;
  endfunction

  function automatic frac_result_t predict_rational(logic [2:0] op,
      logic signed [W-1:0] a_n, logic signed [W-1:0] a_d,
      logic signed [W-1:0] b_n, logic signed [W-1:0] b_d);
    longint an, ad, bn, bd, rn, rd, ta, tb, ma, mb, lcm;
    frac_result_t r;
    an = a_n; ad = a_d; bn = b_n; bd = b_d;
    rn = 0; rd = 1; ta = 0; tb = 0;
    r = '0;
    if (op <= OP_DIV || op == OP_CMP) r.err = (ad == 0) || (bd == 0);
    if (op <= OP_DIV) begin
      case (op)
        OP_ADD: begin rn = an * bd + bn * ad; rd = ad * bd; end
        OP_SUB: begin rn = an * bd - bn * ad; rd = ad * bd; end
        OP_MUL: begin rn = an * bn; rd = ad * bd; end
        default: begin rn = an * bd; rd = ad * bn; end
      endcase
      // products wrap to 32 bits before reduction
      rn = longint'($signed(rn[31:0]));
      rd = longint'($signed(rd[31:0]));
      if (rn == 0) rd = 1;
      reduce_frac(rn, rd);
      if (rd == 0) r.err = 1'b1;
    end else if (op == OP_CMP) begin
      reduce_frac(an, ad);
      reduce_frac(bn, bd);
      if (ad != 0 && bd != 0) begin
        ma = mag(ad);
        mb = mag(bd);
        lcm = (ma / gcd_mag(ma, mb)) * mb;
        ta = an * (lcm / ad);
        tb = bn * (lcm / bd);
      end
      r.cmp = 33'(tb - ta);
    end
    r.num = 32'(rn);
    r.den = 32'(rd);
    return r;
  endfunction

  function automatic logic signed [W-1:0] pick_operand(bit nonzero_bias);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return W'($signed($urandom_range(0, 40)) - 20);
    if (sel < 6) return W'($signed($urandom_range(0, 512)) - 256);
    if (sel == 6 && !nonzero_bias) return '0;
    if (sel == 7) return ($urandom_range(0, 1) != 0) ? 16'sd32767 : -16'sd32767;
    return W'($signed($urandom_range(0, 65534)) - 32767);
  endfunction

  // Offer one item at the falling edge and hold it until it is taken.
  task automatic offer_item(logic [2:0] op, logic signed [W-1:0] an,
      logic signed [W-1:0] ad, logic signed [W-1:0] bn, logic signed [W-1:0] bd,
      bit typed, frac_result_t typed_res);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_op = op; in_a_num = an; in_a_den = ad; in_b_num = bn; in_b_den = bd;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    pending_results.push_back(typed ? typed_res : predict_rational(op, an, ad, bn, bd));
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    frac_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_res_num !== want.num) begin
          $error("res_num: expected %0d, got %0d", want.num, out_res_num);
          fail_count++;
        end
        if (out_res_den !== want.den) begin
          $error("res_den: expected %0d, got %0d", want.den, out_res_den);
          fail_count++;
        end
        if (out_cmp_value !== want.cmp) begin
          $error("cmp_value: expected %0d, got %0d", want.cmp, out_cmp_value);
          fail_count++;
        end
        if (out_zero_den_error !== want.err) begin
          $error("zero_den_error: expected %0d, got %0d", want.err, out_zero_den_error);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rational_arithmetic_unit regression: fail");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold on request, none in the quiet tail.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        out_stall = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    logic [2:0] op;
    logic signed [W-1:0] an, ad, bn, bd;
    int wait_cycles;
    fail_count = 0;
    cycle_count = 0;
    quiet = 1'b0;
    hold_request = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_ADD;
    in_a_num = '0; in_a_den = '0; in_b_num = '0; in_b_den = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      offer_item(DIRECTED[i].op, DIRECTED[i].a_num, DIRECTED[i].a_den,
                 DIRECTED[i].b_num, DIRECTED[i].b_den, DIRECTED[i].typed, DIRECTED[i].res);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 100) hold_request = 1'b1;
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      an = pick_operand(1'b0);
      bn = pick_operand(1'b0);
      // mostly nonzero denominators, zero now and then
      ad = ($urandom_range(0, 24) == 0) ? '0 : pick_operand(1'b1);
      bd = ($urandom_range(0, 24) == 0) ? '0 : pick_operand(1'b1);
      offer_item(op, an, ad, bn, bd, 1'b0, '0);
    end
    in_valid = 1'b0;

    wait_cycles = 0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
      wait_cycles++;
      if (wait_cycles > 200_000) begin
        $display("rational_arithmetic_unit regression: fail");
        $finish;
      end
    end
    repeat (50) @(posedge clk);

    if (fail_count == 0) begin
      $display("rational_arithmetic_unit regression: pass");
    end else begin
      $display("rational_arithmetic_unit regression: fail");
    end
    $finish;
  end
endmodule

[files.f]
rtl/rau_pkg.sv
rtl/rau_datapath.sv
rtl/rau_ctrl.sv
rtl/rational_arithmetic_unit.sv
tb/tb_rational_arithmetic_unit.sv
